>>> sv/afrc_pkg.sv
`default_nettype none

package afrc_pkg;

    localparam int SAMPLE_W         = 32;
    // sample difference magnitude, up to 2^32-1
    localparam int MAG_W            = SAMPLE_W + 1;
    localparam int DCNT_W           = $clog2(MAG_W);
    localparam int FACTOR_W         = 6;
    localparam int CHAN_W           = 2;
    localparam int BYTES_W          = 3;
    localparam int KEEP_W           = 6;
    localparam int ADDR_W           = 4;
    localparam int DATA_W           = 32;

    localparam int DEF_MAX_FACTOR   = 63;
    localparam int DEF_MAX_CHANNELS = 2;

    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_FACTOR   = 2'd1;
    localparam logic [1:0] REG_CHANNELS = 2'd2;
    localparam logic [1:0] REG_BYTES    = 2'd3;

    typedef struct packed {
        logic pass_load;    // present the current frame unchanged
        logic interp_load;  // start an interpolation against the stored frame
        logic upd_prev;     // store the current frame
        logic div_step;     // one restoring division step
        logic acc_step;     // advance to the next interpolation point
    } lane_ctrl_t;

endpackage

`default_nettype wire

>>> sv/afrc_lane.sv
`default_nettype none

module afrc_lane
    import afrc_pkg::*;
#(
    parameter int MAX_FACTOR = DEF_MAX_FACTOR
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire lane_ctrl_t                        ctrl,
    input  wire logic [$clog2(MAX_FACTOR+2)-1:0]   divisor,
    input  wire logic [SAMPLE_W-1:0]               cur,
    output logic      [SAMPLE_W-1:0]               sample
);

    localparam int DIV_W = $clog2(MAX_FACTOR + 2);

    logic [SAMPLE_W-1:0] prev_reg;
    logic [SAMPLE_W-1:0] base_reg;
    logic                neg_reg;
    logic [MAG_W-1:0]    dvd_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [MAG_W-1:0]    qacc_reg;
    logic [DIV_W-1:0]    racc_reg;

    logic [MAG_W-1:0]    diff;
    logic [MAG_W-1:0]    mag;
    logic [DIV_W:0]      rem_sh;
    logic [DIV_W:0]      rem_sub;
    logic                fits;
    logic [DIV_W-1:0]    rem_next;
    logic [MAG_W-1:0]    dvd_next;
    logic [DIV_W:0]      racc_sum;
    logic [DIV_W:0]      racc_sub;
    logic                carry;
    logic [DIV_W-1:0]    racc_next;
    logic [MAG_W-1:0]    qacc_next;
    logic [SAMPLE_W-1:0] q_low;

    assign diff = {cur[SAMPLE_W-1], cur} - {prev_reg[SAMPLE_W-1], prev_reg};
    assign mag  = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;

    // restoring division of the magnitude by the step count
    assign rem_sh   = {rem_reg, dvd_reg[MAG_W-1]};
    assign rem_sub  = rem_sh - {1'b0, divisor};
    assign fits     = (rem_sh >= {1'b0, divisor});
    assign rem_next = fits ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    assign dvd_next = {dvd_reg[MAG_W-2:0], fits};

    // running quotient and remainder of mag*i/divisor
    assign racc_sum  = {1'b0, racc_reg} + {1'b0, rem_reg};
    assign racc_sub  = racc_sum - {1'b0, divisor};
    assign carry     = (racc_sum >= {1'b0, divisor});
    assign racc_next = carry ? racc_sub[DIV_W-1:0] : racc_sum[DIV_W-1:0];
    assign qacc_next = qacc_reg + dvd_reg + MAG_W'(carry);

    assign q_low  = qacc_reg[SAMPLE_W-1:0];
    assign sample = base_reg + (neg_reg ? (~q_low + SAMPLE_W'(1)) : q_low);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else if (ctrl.upd_prev)
        begin
            prev_reg <= cur;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.pass_load)
        begin
            base_reg <= cur;
            neg_reg  <= 1'b0;
            qacc_reg <= '0;
            racc_reg <= '0;
        end
        else if (ctrl.interp_load)
        begin
            base_reg <= prev_reg;
            neg_reg  <= diff[MAG_W-1];
            dvd_reg  <= mag;
            rem_reg  <= '0;
            qacc_reg <= '0;
            racc_reg <= '0;
        end
        else if (ctrl.div_step)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
        else if (ctrl.acc_step)
        begin
            qacc_reg <= qacc_next;
            racc_reg <= racc_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/afrc_merge.sv
`default_nettype none

module afrc_merge
    import afrc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire logic                last_in,
    input  wire logic [SAMPLE_W-1:0] left_in,
    input  wire logic [SAMPLE_W-1:0] right_in,
    input  wire logic [BYTES_W-1:0]  bytes_eff,
    input  wire logic                stereo,
    input  wire logic                out_stall,
    output logic                     can_load,
    output logic                     out_valid,
    output logic [SAMPLE_W-1:0]      out_left,
    output logic [SAMPLE_W-1:0]      out_right,
    output logic                     last
);

    function automatic logic [SAMPLE_W-1:0] wrap_sample(
        input logic [SAMPLE_W-1:0] v,
        input logic [BYTES_W-1:0]  nb
    );
        logic [SAMPLE_W-1:0] r;
        case (nb)
            3'd1:    r = {{24{v[7]}}, v[7:0]};
            3'd2:    r = {{16{v[15]}}, v[15:0]};
            3'd3:    r = {{8{v[23]}}, v[23:0]};
            default: r = v;
        endcase
        return r;
    endfunction

    logic                valid_reg;
    logic [SAMPLE_W-1:0] left_reg;
    logic [SAMPLE_W-1:0] right_reg;
    logic                last_reg;

    assign can_load  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_left  = left_reg;
    assign out_right = right_reg;
    assign last      = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            left_reg  <= wrap_sample(left_in, bytes_eff);
            right_reg <= stereo ? wrap_sample(right_in, bytes_eff) : '0;
            last_reg  <= last_in;
        end
    end

endmodule

`default_nettype wire

>>> sv/audio_frame_rate_changer.sv
// audio frame rate changer: takes one frame (left and right sample, sign-extended to
// 32 bits) per word and either drops frames (mode 0, keeps the first and then every
// (factor+1)-th frame) or stretches time (mode 1, emits factor+1 linearly interpolated
// frames between the stored frame and the new one, truncating toward zero). outputs
// wrap to sample_bytes*8 bits; out_right is zero for mono. an interpolated frame goes
// through the per-channel restoring divider (difference magnitude over factor+1), one
// setup step, then factor+1 words of output, one word per cycle while out_stall is low,
// from an incremental quotient/remainder accumulator. in_stall is high while a frame is
// being worked on; configuration must only be written while idle.
`default_nettype none

module audio_frame_rate_changer
    import afrc_pkg::*;
#(
    parameter int MAX_FACTOR   = DEF_MAX_FACTOR,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // apb configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    output logic      [DATA_W-1:0]   prdata,
    output logic                     pready,
    // input words
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [SAMPLE_W-1:0] sample_left,
    input  wire logic [SAMPLE_W-1:0] sample_right,
    // output words
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [SAMPLE_W-1:0] out_left,
    output logic      [SAMPLE_W-1:0] out_right,
    output logic                     last
);

    localparam int DIV_W = $clog2(MAX_FACTOR + 2);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_STEP = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    // configuration registers
    logic                mode_reg;
    logic [FACTOR_W-1:0] factor_reg;
    logic [CHAN_W-1:0]   channels_reg;
    logic [BYTES_W-1:0]  bytes_reg;

    // sequencer state
    logic [1:0]          state_reg, state_next;
    logic                first_seen_reg, first_seen_next;
    logic [KEEP_W-1:0]   keep_cnt_reg, keep_cnt_next;
    logic [DIV_W-1:0]    div_reg, div_next;
    logic [DIV_W-1:0]    idx_reg, idx_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic                single_reg, single_next;

    logic                cfg_wr;
    logic                in_acc;
    logic [DIV_W-1:0]    eff_factor;
    logic [BYTES_W-1:0]  bytes_eff;
    logic                stereo;
    logic                emit_last;
    logic                can_load;
    logic                merge_load;
    lane_ctrl_t          ctrl;

    logic [SAMPLE_W-1:0] lane_cur    [MAX_CHANNELS];
    logic [SAMPLE_W-1:0] lane_sample [MAX_CHANNELS];
    logic [SAMPLE_W-1:0] right_raw;

    // ---------------------------------------------------------------------
    // configuration port, always ready
    // ---------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            factor_reg   <= '0;
            channels_reg <= CHAN_W'(1);
            bytes_reg    <= BYTES_W'(2);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_MODE:     mode_reg     <= pwdata[0];
                REG_FACTOR:   factor_reg   <= pwdata[FACTOR_W-1:0];
                REG_CHANNELS: channels_reg <= pwdata[CHAN_W-1:0];
                REG_BYTES:    bytes_reg    <= pwdata[BYTES_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MODE:     prdata = {{(DATA_W-1){1'b0}}, mode_reg};
            REG_FACTOR:   prdata = {{(DATA_W-FACTOR_W){1'b0}}, factor_reg};
            REG_CHANNELS: prdata = {{(DATA_W-CHAN_W){1'b0}}, channels_reg};
            REG_BYTES:    prdata = {{(DATA_W-BYTES_W){1'b0}}, bytes_reg};
            default:      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // effective settings: clamp factor, channel count and sample size
    // ---------------------------------------------------------------------
    assign eff_factor = DIV_W'((int'(factor_reg) > MAX_FACTOR) ? MAX_FACTOR
                                                               : int'(factor_reg));
    assign bytes_eff  = (bytes_reg == '0)         ? BYTES_W'(1) :
                        (bytes_reg > BYTES_W'(4)) ? BYTES_W'(4) : bytes_reg;
    assign stereo     = (channels_reg == CHAN_W'(2) || channels_reg == CHAN_W'(3))
                        && (MAX_CHANNELS > 1);

    // ---------------------------------------------------------------------
    // sequencer: accept or drop frames, divide, step through interpolation points
    // ---------------------------------------------------------------------
    assign in_stall   = (state_reg != S_IDLE);
    assign in_acc     = in_valid && !in_stall;
    assign emit_last  = single_reg || (idx_reg == div_reg);
    assign merge_load = (state_reg == S_EMIT) && can_load;

    always_comb
    begin
        state_next      = state_reg;
        first_seen_next = first_seen_reg;
        keep_cnt_next   = keep_cnt_reg;
        div_next        = div_reg;
        idx_next        = idx_reg;
        dcnt_next       = dcnt_reg;
        single_next     = single_reg;
        ctrl            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (!mode_reg)
                    begin
                        // drop mode: counter wraps once it reaches the factor
                        if (int'(keep_cnt_reg) >= int'(eff_factor))
                            keep_cnt_next = '0;
                        else
                            keep_cnt_next = keep_cnt_reg + KEEP_W'(1);
                        if (keep_cnt_reg == '0)
                        begin
                            ctrl.pass_load = 1'b1;
                            single_next    = 1'b1;
                            state_next     = S_EMIT;
                        end
                    end
                    else if (!first_seen_reg)
                    begin
                        // very first frame in stretch mode passes through
                        ctrl.pass_load  = 1'b1;
                        ctrl.upd_prev   = 1'b1;
                        first_seen_next = 1'b1;
                        single_next     = 1'b1;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        ctrl.interp_load = 1'b1;
                        ctrl.upd_prev    = 1'b1;
                        div_next         = eff_factor + DIV_W'(1);
                        dcnt_next        = '0;
                        single_next      = 1'b0;
                        state_next       = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                ctrl.div_step = 1'b1;
                dcnt_next     = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(MAG_W - 1))
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                // first interpolation point
                ctrl.acc_step = 1'b1;
                idx_next      = DIV_W'(1);
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (can_load)
                begin
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctrl.acc_step = 1'b1;
                        idx_next      = idx_reg + DIV_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            first_seen_reg <= 1'b0;
            keep_cnt_reg   <= '0;
            div_reg        <= '0;
            idx_reg        <= '0;
            dcnt_reg       <= '0;
            single_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_seen_reg <= first_seen_next;
            keep_cnt_reg   <= keep_cnt_next;
            div_reg        <= div_next;
            idx_reg        <= idx_next;
            dcnt_reg       <= dcnt_next;
            single_reg     <= single_next;
        end
    end

    // ---------------------------------------------------------------------
    // one lane per channel
    // ---------------------------------------------------------------------
    assign lane_cur[0] = sample_left;

    generate
        if (MAX_CHANNELS > 1)
        begin : g_right
            assign lane_cur[1] = sample_right;
            assign right_raw   = lane_sample[1];
        end
        else
        begin : g_mono
            assign right_raw = '0;
        end
    endgenerate

    genvar ch;
    generate
        for (ch = 0; ch < MAX_CHANNELS; ch++)
        begin : g_lane
            afrc_lane #(
                .MAX_FACTOR (MAX_FACTOR)
            ) u_lane (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .divisor (div_reg),
                .cur     (lane_cur[ch]),
                .sample  (lane_sample[ch])
            );
        end
    endgenerate

    // ---------------------------------------------------------------------
    // merge lanes into the output word register
    // ---------------------------------------------------------------------
    afrc_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (merge_load),
        .last_in   (emit_last),
        .left_in   (lane_sample[0]),
        .right_in  (right_raw),
        .bytes_eff (bytes_eff),
        .stereo    (stereo),
        .out_stall (out_stall),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_left  (out_left),
        .out_right (out_right),
        .last      (last)
    );

endmodule

`default_nettype wire
